FILE: rtl/core/sqd_pkg.sv
`timescale 1ns / 1ps
package sqd_pkg;

   localparam int JOB_ID_W      = 17;
   localparam int QUEUE_INDEX_W = 3;
   localparam int ACTIVE_W      = 4;
   localparam int STATUS_W      = 2;

   localparam logic [ACTIVE_W-1:0] ACTIVE_QUEUES_RESET = 4'd5;

   localparam int FRONT_DEPTH  = 2;
   localparam int FRONT_PTR_W  = $clog2(FRONT_DEPTH);
   localparam int FRONT_FILL_W = $clog2(FRONT_DEPTH + 1);

   typedef enum logic [0:0] {
      OP_INSERT = 1'b0,
      OP_SERVE  = 1'b1
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK       = 2'd0,
      STATUS_NOTHING  = 2'd1,
      STATUS_FULL     = 2'd2,
      STATUS_INACTIVE = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      BK_IDLE   = 2'd0,
      BK_SCAN   = 2'd1,
      BK_DECIDE = 2'd2,
      BK_FETCH  = 2'd3
   } state_type;

   typedef struct packed {
      op_type                   op;
      logic [JOB_ID_W-1:0]      job_id;
      logic [QUEUE_INDEX_W-1:0] queue_index;
   } cmd_type;

   typedef struct packed {
      logic [QUEUE_INDEX_W-1:0] chosen_queue;
      logic [JOB_ID_W-1:0]      served_job_id;
      logic                     moved;
      status_type               status;
   } rsp_type;

endpackage

FILE: rtl/core/sqd_front.sv
`timescale 1ns / 1ps
module sqd_front
   import sqd_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   output logic                     full,
   input  logic                     req_type,
   input  logic [JOB_ID_W-1:0]      job_id,
   input  logic [QUEUE_INDEX_W-1:0] queue_index,
   output logic                     cmd_valid,
   output cmd_type                  cmd,
   input  logic                     cmd_pop
);

   cmd_type                 fifo_ff [FRONT_DEPTH];
   logic [FRONT_PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [FRONT_PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [FRONT_FILL_W-1:0] fill_ff, fill_in;
   logic                    do_push, do_pop;
   cmd_type                 word_in;

   // classify the incoming word
   always_comb begin
      word_in.op          = req_type ? OP_SERVE : OP_INSERT;
      word_in.job_id      = job_id;
      word_in.queue_index = queue_index;
   end

   assign full      = (fill_ff == FRONT_FILL_W'(FRONT_DEPTH));
   assign cmd_valid = (fill_ff != '0);
   assign cmd       = fifo_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = cmd_pop && cmd_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == FRONT_PTR_W'(FRONT_DEPTH - 1)) ? '0
                                                                   : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == FRONT_PTR_W'(FRONT_DEPTH - 1)) ? '0
                                                                   : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         fifo_ff[wr_ptr_ff] <= word_in;
      end
   end

endmodule

FILE: rtl/core/sqd_back.sv
`timescale 1ns / 1ps
module sqd_back
   import sqd_pkg::*;
#(
   parameter int MAX_QUEUES  = 8,
   parameter int STACK_DEPTH = 1024
)
(
   input  logic                clock,
   input  logic                reset,
   input  logic [ACTIVE_W-1:0] active_queues,
   input  logic                cmd_valid,
   input  cmd_type             cmd,
   output logic                cmd_pop,
   output logic                rsp_valid,
   output rsp_type             rsp,
   input  logic                rsp_pop
);

   localparam int QIW  = $clog2(MAX_QUEUES);
   localparam int CNTW = $clog2(MAX_QUEUES + 1);
   localparam int ACW  = (CNTW > ACTIVE_W) ? CNTW : ACTIVE_W;
   localparam int LW   = $clog2(STACK_DEPTH + 1);
   localparam int AW   = $clog2(STACK_DEPTH);

   state_type           state_ff, state_in;
   cmd_type             cmd_ff;
   logic [QIW-1:0]      idx_ff, idx_in;
   logic [QIW-1:0]      min_idx_ff, min_idx_in, max_idx_ff, max_idx_in;
   logic [LW-1:0]       min_len_ff, min_len_in, max_len_ff, max_len_in;
   logic                qi_zero_ff, qi_zero_in;
   logic [LW-1:0]       len_ff [MAX_QUEUES];
   logic [LW-1:0]       count_ff, count_in;
   logic [JOB_ID_W-1:0] stack_mem [STACK_DEPTH];
   logic [JOB_ID_W-1:0] rd_data_ff;
   logic [QIW-1:0]      serve_q_ff, serve_q_in;
   logic                moved_ff, moved_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_ff, rsp_in;

   logic                take, scan_en, decide_en, fetch_en;
   logic [ACW-1:0]      n_act, qi_wide;
   logic [LW-1:0]       cur_len;
   logic                idx_first, idx_last, qi_here;
   logic                inactive, stack_empty, stack_full, nothing;
   logic                serve_ok, insert_ok;
   logic [QIW-1:0]      serve_q;
   logic                len_we;
   logic [QIW-1:0]      len_waddr;
   logic [LW-1:0]       len_in;
   logic                mem_we, mem_re;
   logic [AW-1:0]       mem_waddr, mem_raddr;
   logic [LW-1:0]       count_dec;

   // active count clamped to one..MAX_QUEUES
   always_comb begin
      priority if (active_queues == '0) begin
         n_act = ACW'(1);
      end else if (ACW'(active_queues) > ACW'(MAX_QUEUES)) begin
         n_act = ACW'(MAX_QUEUES);
      end else begin
         n_act = ACW'(active_queues);
      end
   end

   assign qi_wide     = ACW'(cmd_ff.queue_index);
   assign cur_len     = len_ff[idx_ff];
   assign idx_first   = (idx_ff == '0);
   assign idx_last    = (ACW'(idx_ff) == n_act - ACW'(1));
   assign qi_here     = (ACW'(idx_ff) == qi_wide);
   assign count_dec   = count_ff - LW'(1);
   assign inactive    = (qi_wide >= n_act);
   assign stack_empty = (count_ff == '0);
   assign stack_full  = (count_ff == LW'(STACK_DEPTH));
   assign nothing     = stack_empty || (qi_zero_ff && (max_len_ff == '0));
   assign serve_q     = qi_zero_ff ? max_idx_ff : QIW'(cmd_ff.queue_index);
   assign serve_ok    = (cmd_ff.op == OP_SERVE) && !inactive && !nothing;
   assign insert_ok   = (cmd_ff.op == OP_INSERT) && !stack_full;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE:   if (take) state_in = BK_SCAN;
         BK_SCAN:   if (idx_last) state_in = BK_DECIDE;
         BK_DECIDE: state_in = serve_ok ? BK_FETCH : BK_IDLE;
         BK_FETCH:  state_in = BK_IDLE;
         default:   state_in = BK_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      take      = 1'b0;
      scan_en   = 1'b0;
      decide_en = 1'b0;
      fetch_en  = 1'b0;
      unique case (state_ff)
         BK_IDLE:   take      = cmd_valid && (!rsp_valid_ff || rsp_pop);
         BK_SCAN:   scan_en   = 1'b1;
         BK_DECIDE: decide_en = 1'b1;
         BK_FETCH:  fetch_en  = 1'b1;
         default:   take      = 1'b0;
      endcase
   end

   assign cmd_pop = take;

   // running first minimum and first maximum over the active counters
   always_comb begin
      idx_in     = idx_ff;
      min_idx_in = min_idx_ff;
      min_len_in = min_len_ff;
      max_idx_in = max_idx_ff;
      max_len_in = max_len_ff;
      qi_zero_in = qi_zero_ff;
      if (take) begin
         idx_in = '0;
      end else if (scan_en) begin
         idx_in = idx_ff + QIW'(1);
         if (idx_first) begin
            min_idx_in = idx_ff;
            min_len_in = cur_len;
            max_idx_in = idx_ff;
            max_len_in = cur_len;
            qi_zero_in = qi_here && (cur_len == '0);
         end else begin
            if (cur_len < min_len_ff) begin
               min_idx_in = idx_ff;
               min_len_in = cur_len;
            end
            if (cur_len > max_len_ff) begin
               max_idx_in = idx_ff;
               max_len_in = cur_len;
            end
            if (qi_here && (cur_len == '0)) begin
               qi_zero_in = 1'b1;
            end
         end
      end
   end

   // decision and updates
   always_comb begin
      count_in     = count_ff;
      len_we       = 1'b0;
      len_waddr    = min_idx_ff;
      len_in       = len_ff[min_idx_ff] + LW'(1);
      mem_we       = 1'b0;
      mem_re       = 1'b0;
      mem_waddr    = count_ff[AW-1:0];
      mem_raddr    = count_dec[AW-1:0];
      serve_q_in   = serve_q_ff;
      moved_in     = moved_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_pop;
      rsp_in       = rsp_ff;
      if (decide_en) begin
         if (cmd_ff.op == OP_INSERT) begin
            rsp_valid_in         = 1'b1;
            rsp_in.served_job_id = '0;
            rsp_in.moved         = 1'b0;
            if (insert_ok) begin
               mem_we              = 1'b1;
               count_in            = count_ff + LW'(1);
               len_we              = 1'b1;
               rsp_in.chosen_queue = QUEUE_INDEX_W'(min_idx_ff);
               rsp_in.status       = STATUS_OK;
            end else begin
               rsp_in.chosen_queue = '0;
               rsp_in.status       = STATUS_FULL;
            end
         end else if (serve_ok) begin
            mem_re     = 1'b1;
            count_in   = count_dec;
            len_we     = 1'b1;
            len_waddr  = serve_q;
            len_in     = len_ff[serve_q] - LW'(1);
            serve_q_in = serve_q;
            moved_in   = qi_zero_ff && (max_idx_ff != QIW'(cmd_ff.queue_index));
         end else begin
            rsp_valid_in         = 1'b1;
            rsp_in.chosen_queue  = '0;
            rsp_in.served_job_id = '0;
            rsp_in.moved         = 1'b0;
            rsp_in.status        = inactive ? STATUS_INACTIVE : STATUS_NOTHING;
         end
      end else if (fetch_en) begin
         rsp_valid_in         = 1'b1;
         rsp_in.chosen_queue  = QUEUE_INDEX_W'(serve_q_ff);
         rsp_in.served_job_id = rd_data_ff;
         rsp_in.moved         = moved_ff;
         rsp_in.status        = STATUS_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < MAX_QUEUES; i++) begin
            len_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (len_we) begin
            len_ff[len_waddr] <= len_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         cmd_ff <= cmd;
      end
      idx_ff     <= idx_in;
      min_idx_ff <= min_idx_in;
      min_len_ff <= min_len_in;
      max_idx_ff <= max_idx_in;
      max_len_ff <= max_len_in;
      qi_zero_ff <= qi_zero_in;
      serve_q_ff <= serve_q_in;
      moved_ff   <= moved_in;
      rsp_ff     <= rsp_in;
   end

   // job stack
   always_ff @(posedge clock) begin
      if (mem_we) begin
         stack_mem[mem_waddr] <= cmd_ff.job_id;
      end
      if (mem_re) begin
         rd_data_ff <= stack_mem[mem_raddr];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

FILE: rtl/core/shortest_queue_dispatcher_core.sv
`timescale 1ns / 1ps
// join-shortest-queue dispatcher with one shared stack of job ids
// request side is a queue: drive req_* and raise req_push, a word is taken
//    at a clock edge with req_push high and req_full low
// response side is a queue: while rsp_empty is low the oldest response is on
//    rsp_*, and rsp_pop high at a clock edge takes it
// csr channel writes the number of active queues, csr_ready is always high;
//    write it only while no request is outstanding
// a two-word front queue takes requests while the back engine works
// the engine scans the active queue counters one per cycle, then decides;
//    an insert response is registered from the decide state, and a serve
//    adds a fetch state for the stack memory read before its response
// a held response does not stop the front queue; the engine waits to start
//    the next request until the response register is free
// reset empties both queues, clears the counters and the stack depth and
//    sets five active queues; stack memory contents are not cleared
module shortest_queue_dispatcher_core
   import sqd_pkg::*;
#(
   parameter int MAX_QUEUES  = 8,
   parameter int STACK_DEPTH = 1024
)
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_push,
   output logic                     req_full,
   input  logic                     req_type,
   input  logic [JOB_ID_W-1:0]      req_job_id,
   input  logic [QUEUE_INDEX_W-1:0] req_queue_index,
   output logic                     rsp_empty,
   input  logic                     rsp_pop,
   output logic [QUEUE_INDEX_W-1:0] rsp_chosen_queue,
   output logic [JOB_ID_W-1:0]      rsp_served_job_id,
   output logic                     rsp_moved,
   output logic [STATUS_W-1:0]      rsp_status,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [ACTIVE_W-1:0]      csr_active_queues
);

   logic [ACTIVE_W-1:0] active_queues_ff, active_queues_in;
   logic                cmd_valid, cmd_pop, rsp_valid;
   cmd_type             cmd;
   rsp_type             rsp;

   assign csr_ready        = 1'b1;
   assign active_queues_in = (csr_valid && csr_ready) ? csr_active_queues : active_queues_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_queues_ff <= ACTIVE_QUEUES_RESET;
      end else begin
         active_queues_ff <= active_queues_in;
      end
   end

   sqd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .push        (req_push),
      .full        (req_full),
      .req_type    (req_type),
      .job_id      (req_job_id),
      .queue_index (req_queue_index),
      .cmd_valid   (cmd_valid),
      .cmd         (cmd),
      .cmd_pop     (cmd_pop)
   );

   sqd_back #(
      .MAX_QUEUES  (MAX_QUEUES),
      .STACK_DEPTH (STACK_DEPTH)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .active_queues (active_queues_ff),
      .cmd_valid     (cmd_valid),
      .cmd           (cmd),
      .cmd_pop       (cmd_pop),
      .rsp_valid     (rsp_valid),
      .rsp           (rsp),
      .rsp_pop       (rsp_pop)
   );

   assign rsp_empty         = !rsp_valid;
   assign rsp_chosen_queue  = rsp.chosen_queue;
   assign rsp_served_job_id = rsp.served_job_id;
   assign rsp_moved         = rsp.moved;
   assign rsp_status        = rsp.status;

endmodule
